// File: hdl/eoh_pkg.sv
// ----------------------------------------------------------------------------
// eoh_pkg
// Shared types and constants of the escape orbit histogram engine.
// ----------------------------------------------------------------------------
`default_nettype none

package eoh_pkg;

  localparam int GRID_SIDE_DEF   = 256;
  localparam int ORBIT_DEPTH_DEF = 1024;
  localparam int FRAC_BITS_DEF   = 28;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 64;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 31;

  localparam logic [CFG_ADDR_W-1:0] REG_MAX_ITER  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MIN_ITER  = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ESC_LIMIT = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_RANGE     = 2'd3;

  localparam logic [10:0] MAX_ITER_RST  = 11'd1024;
  localparam logic [9:0]  MIN_ITER_RST  = 10'd0;
  localparam logic [30:0] ESC_LIMIT_RST = 31'h4000_0000;
  localparam logic [2:0]  RANGE_RST     = 3'd2;

  localparam logic [31:0] COUNT_MAX   = 32'hFFFF_FFFF;
  localparam logic [7:0]  LEVEL_SCALE = 8'hFF;

  // Controller to datapath commands
  typedef struct packed {
    logic start;
    logic mul;
    logic add;
    logic check;
    logic orb_rd;
    logic map;
    logic div_start;
    logic hist_rd_map;
    logic hist_wr;
    logic hist_rd_idx;
    logic lvl_start;
    logic clr;
    logic emit;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic zero_iter;
    logic op_read;
    logic esc_now;
    logic rec_ok;
    logic last_iter;
    logic rep_end;
    logic on_grid;
    logic div_busy;
    logic lvl_busy;
    logic clr_end;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// File: hdl/escape_orbit_histogram.sv
// ----------------------------------------------------------------------------
// escape_orbit_histogram
// Orbit-density histogram engine: traces points, accumulates hit counts.
// ----------------------------------------------------------------------------
// One item at a time. After reset the histogram memory is swept to zero, one
// cell a cycle, with in_tready low; config writes are taken during the sweep.
// A trace item (tuser 0) runs each iteration as multiply, add and saturate,
// escape check; then, on an escape at or past the minimum iteration, it
// replays the stored orbit: a point outside the grid is skipped, a point
// inside goes through the cell divider, QW = clog2(7*(GRID_SIDE-1)+1) bits
// wide (11 for the default grid), and raises its cell. A cell read (tuser 1)
// reads the cell and runs the 40-bit level divider. The result then goes into
// the output register, which holds it while the next item is accepted.
// ----------------------------------------------------------------------------
`default_nettype none

module escape_orbit_histogram #(
  parameter int GRID_SIDE   = eoh_pkg::GRID_SIDE_DEF,
  parameter int ORBIT_DEPTH = eoh_pkg::ORBIT_DEPTH_DEF,
  parameter int FRAC_BITS   = eoh_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // input item
  input  wire logic                            in_tvalid,
  output logic                                 in_tready,
  // c_re[31:0], c_im[63:32], cell_index[79:64]
  input  wire logic [eoh_pkg::IN_DATA_W-1:0]   in_tdata,
  // op[0]: 0 trace a point, 1 read a cell
  input  wire logic                            in_tuser,
  // result item
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  // escaped[0], escape_step[11:1], plotted[22:12], cell_count[54:23],
  // cell_level[62:55], zero pad[63]
  output logic [eoh_pkg::OUT_DATA_W-1:0]       out_tdata,
  // configuration writes
  input  wire logic                            cfg_we,
  input  wire logic [eoh_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [eoh_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

  eoh_pkg::cmd_t cmd;
  eoh_pkg::sts_t sts;
  logic          in_ready;

  // Controller: accept an item only in idle, walk it through its phases.
  eoh_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_ready  (in_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: iteration, orbit store, histogram and output register.
  eoh_dp #(
    .GRID_SIDE   (GRID_SIDE),
    .ORBIT_DEPTH (ORBIT_DEPTH),
    .FRAC_BITS   (FRAC_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  assign in_tready = in_ready;

endmodule

`default_nettype wire

// File: hdl/eoh_div.sv
// ----------------------------------------------------------------------------
// eoh_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module eoh_div #(
  parameter int NW = 8,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [NW-1:0]      quo
);

  localparam int CNT_W = $clog2(NW + 1);

  logic [NW-1:0]    acc_r;
  logic [DW-1:0]    rem_r;
  logic [DW-1:0]    den_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;

  logic [DW:0]      trial;
  logic             fits;

  assign trial = {rem_r, acc_r[NW-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(NW);
      acc_r  <= num;
      rem_r  <= '0;
      den_r  <= den;
    end else if (busy_r) begin
      // shift in one dividend bit, subtract when it fits
      rem_r  <= fits ? DW'(trial - {1'b0, den_r}) : trial[DW-1:0];
      acc_r  <= {acc_r[NW-2:0], fits};
      cnt_r  <= cnt_r - 1'b1;
      busy_r <= cnt_r != CNT_W'(1);
    end
  end

  assign busy = busy_r;
  assign quo  = acc_r;

endmodule

`default_nettype wire

// File: hdl/eoh_dp.sv
// ----------------------------------------------------------------------------
// eoh_dp
// Datapath: config registers, orbit iteration, orbit store, grid mapping,
// histogram memory, level divider and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module eoh_dp #(
  parameter int GRID_SIDE   = eoh_pkg::GRID_SIDE_DEF,
  parameter int ORBIT_DEPTH = eoh_pkg::ORBIT_DEPTH_DEF,
  parameter int FRAC_BITS   = eoh_pkg::FRAC_BITS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire eoh_pkg::cmd_t                   cmd,
  output eoh_pkg::sts_t                        sts,
  input  wire logic                            in_tuser,
  input  wire logic [eoh_pkg::IN_DATA_W-1:0]   in_tdata,
  input  wire logic                            cfg_we,
  input  wire logic [eoh_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [eoh_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output logic                                 out_tvalid,
  input  wire logic                            out_tready,
  output logic [eoh_pkg::OUT_DATA_W-1:0]       out_tdata
);

  localparam int CELLS = GRID_SIDE * GRID_SIDE;
  localparam int AW    = $clog2(CELLS);
  localparam int OW    = (ORBIT_DEPTH > 1) ? $clog2(ORBIT_DEPTH) : 1;
  localparam int CW    = $clog2(ORBIT_DEPTH + 1);
  localparam int GW    = $clog2(GRID_SIDE);
  localparam int PW    = 32 + GW;
  localparam int QW    = $clog2(7 * (GRID_SIDE - 1) + 1);

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647)       return 32'sh7FFF_FFFF;
    else if (v < -66'sd2147483648) return 32'sh8000_0000;
    else                           return v[31:0];
  endfunction

  // configuration
  logic [10:0] max_it_r;
  logic [9:0]  min_it_r;
  logic [30:0] esc_lim_r;
  logic [2:0]  range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_it_r  <= eoh_pkg::MAX_ITER_RST;
      min_it_r  <= eoh_pkg::MIN_ITER_RST;
      esc_lim_r <= eoh_pkg::ESC_LIMIT_RST;
      range_r   <= eoh_pkg::RANGE_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        eoh_pkg::REG_MAX_ITER:  max_it_r  <= cfg_wdata[10:0];
        eoh_pkg::REG_MIN_ITER:  min_it_r  <= cfg_wdata[9:0];
        eoh_pkg::REG_ESC_LIMIT: esc_lim_r <= cfg_wdata;
        eoh_pkg::REG_RANGE:     range_r   <= cfg_wdata[2:0];
        default: ;
      endcase
    end
  end

  // item and iteration state
  logic               op_r;
  logic signed [31:0] cre_r, cim_r, zr_r, zi_r;
  logic [15:0]        idx_r;
  logic signed [63:0] prr_r, pii_r, pri_r;
  logic [10:0]        k_r, step_r, plotted_r;
  logic               esc_r;
  logic [CW-1:0]      rep_cnt_r, rep_n_r;

  logic signed [64:0] diff_sq;
  logic signed [65:0] nr, ni;
  logic signed [32:0] dr, di;
  logic [32:0]        adr, adi;
  logic [33:0]        manh_dist;
  logic               esc_now, rec_ok, in_store;
  logic [10:0]        kdiff;
  logic [31:0]        cnt32;

  assign diff_sq = {prr_r[63], prr_r} - {pii_r[63], pii_r};
  assign nr      = 66'(diff_sq >>> FRAC_BITS) + 66'(cre_r);
  assign ni      = 66'(pri_r >>> (FRAC_BITS - 1)) + 66'(cim_r);

  assign dr        = 33'(zr_r) - 33'(cre_r);
  assign di        = 33'(zi_r) - 33'(cim_r);
  assign adr       = dr[32] ? 33'(-dr) : 33'(dr);
  assign adi       = di[32] ? 33'(-di) : 33'(di);
  assign manh_dist = 34'(adr) + 34'(adi);
  assign esc_now   = manh_dist > 34'(esc_lim_r);

  assign rec_ok   = k_r >= 11'(min_it_r);
  assign kdiff    = k_r - 11'(min_it_r);
  assign in_store = rec_ok && (32'(kdiff) < 32'(ORBIT_DEPTH));
  assign cnt32    = 32'(kdiff) + 32'd1;

  // orbit store
  logic [63:0] orbit_mem [ORBIT_DEPTH];
  logic [63:0] orb_q_r;

  always_ff @(posedge clk) begin
    if (cmd.check && in_store) begin
      orbit_mem[OW'(kdiff)] <= {zr_r, zi_r};
    end
    if (cmd.orb_rd) begin
      orb_q_r <= orbit_mem[OW'(rep_n_r)];
    end
  end

  // grid mapping
  logic [2:0]         rng;
  logic signed [33:0] span, ux, uy;
  logic               on_grid;
  logic               in_r;
  logic [PW-1:0]      px_r, py_r;

  assign rng     = (range_r == 3'd0) ? 3'd1 : range_r;
  assign span    = 34'(rng) <<< FRAC_BITS;
  assign ux      = 34'($signed(orb_q_r[63:32])) + span;
  assign uy      = 34'($signed(orb_q_r[31:0])) + span;
  assign on_grid = !ux[33] && !uy[33] && (ux <= (span <<< 1)) && (uy <= (span <<< 1));

  logic [QW-1:0] xq, yq;
  logic          xbusy, ybusy;

  eoh_div #(.NW(QW), .DW(3)) u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (QW'(px_r >> (FRAC_BITS + 1))),
    .den   (rng),
    .busy  (xbusy),
    .quo   (xq)
  );

  eoh_div #(.NW(QW), .DW(3)) u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (QW'(py_r >> (FRAC_BITS + 1))),
    .den   (rng),
    .busy  (ybusy),
    .quo   (yq)
  );

  // histogram memory
  logic [31:0]   hist_mem [CELLS];
  logic [31:0]   hist_q_r;
  logic [AW-1:0] cell_addr, rd_addr, hwa_r, clr_addr_r, wa;
  logic [31:0]   inc, wd;
  logic          we, rd_en;
  logic [31:0]   peak_r, cnt_r, cnt_sel;
  logic          idx_ok;

  assign cell_addr = AW'(xq) + AW'(yq) * AW'(GRID_SIDE);
  assign idx_ok    = 32'(idx_r) < 32'(CELLS);
  assign rd_addr   = cmd.hist_rd_idx ? AW'(idx_r) : cell_addr;
  assign rd_en     = cmd.hist_rd_idx || cmd.hist_rd_map;
  assign inc       = (hist_q_r == eoh_pkg::COUNT_MAX) ? hist_q_r : hist_q_r + 32'd1;
  assign we        = cmd.clr || cmd.hist_wr;
  assign wa        = cmd.clr ? clr_addr_r : hwa_r;
  assign wd        = cmd.clr ? 32'd0 : inc;
  assign cnt_sel   = idx_ok ? hist_q_r : 32'd0;

  always_ff @(posedge clk) begin
    if (we) begin
      hist_mem[wa] <= wd;
    end
    if (rd_en) begin
      hist_q_r <= hist_mem[rd_addr];
    end
  end

  // level divider
  logic [39:0] lvl_q;
  logic        lvl_busy;

  eoh_div #(.NW(40), .DW(32)) u_div_lvl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.lvl_start),
    .num   (40'(cnt_sel) * 40'(eoh_pkg::LEVEL_SCALE)),
    .den   (peak_r),
    .busy  (lvl_busy),
    .quo   (lvl_q)
  );

  // sequencing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      peak_r     <= '0;
    end else begin
      if (cmd.clr) clr_addr_r <= clr_addr_r + 1'b1;
      if (cmd.hist_wr && inc > peak_r) peak_r <= inc;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r      <= in_tuser;
      cre_r     <= in_tdata[31:0];
      cim_r     <= in_tdata[63:32];
      idx_r     <= in_tdata[79:64];
      zr_r      <= in_tdata[31:0];
      zi_r      <= in_tdata[63:32];
      k_r       <= '0;
      esc_r     <= 1'b0;
      step_r    <= max_it_r;
      plotted_r <= '0;
      rep_n_r   <= '0;
      rep_cnt_r <= '0;
    end
    if (cmd.mul) begin
      prr_r <= zr_r * zr_r;
      pii_r <= zi_r * zi_r;
      pri_r <= zr_r * zi_r;
    end
    if (cmd.add) begin
      zr_r <= sat32(nr);
      zi_r <= sat32(ni);
    end
    if (cmd.check) begin
      if (esc_now) begin
        esc_r     <= 1'b1;
        step_r    <= k_r;
        rep_cnt_r <= (cnt32 > 32'(ORBIT_DEPTH)) ? CW'(ORBIT_DEPTH) : CW'(cnt32);
      end else begin
        k_r <= k_r + 11'd1;
      end
    end
    if (cmd.map) begin
      in_r    <= on_grid;
      px_r    <= PW'(ux[31:0]) * PW'(GRID_SIDE - 1);
      py_r    <= PW'(uy[31:0]) * PW'(GRID_SIDE - 1);
      rep_n_r <= rep_n_r + 1'b1;
    end
    if (cmd.hist_rd_map) hwa_r <= cell_addr;
    if (cmd.hist_wr) plotted_r <= plotted_r + 11'd1;
    if (cmd.lvl_start) cnt_r <= cnt_sel;
  end

  // output register
  logic        out_valid_r;
  logic [62:0] out_data_r;
  logic [7:0]  lvl;

  assign lvl = (peak_r == 32'd0) ? 8'd0 : lvl_q[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if (op_r) begin
        out_data_r <= {lvl, cnt_r, 23'd0};
      end else begin
        out_data_r <= {8'd0, 32'd0, plotted_r, step_r, esc_r};
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_data_r};

  assign sts.zero_iter = max_it_r == 11'd0;
  assign sts.op_read   = in_tuser;
  assign sts.esc_now   = esc_now;
  assign sts.rec_ok    = rec_ok;
  assign sts.last_iter = (k_r + 11'd1) == max_it_r;
  assign sts.rep_end   = rep_n_r == rep_cnt_r;
  assign sts.on_grid   = in_r;
  assign sts.div_busy  = xbusy || ybusy;
  assign sts.lvl_busy  = lvl_busy;
  assign sts.clr_end   = clr_addr_r == AW'(CELLS - 1);
  assign sts.out_free  = !out_valid_r || out_tready;

  a_peak_monotonic: assert property (@(posedge clk)
    disable iff (!rst_n) $past(rst_n) |-> peak_r >= $past(peak_r))
    else $error("peak count decreased");

  a_emit_free: assert property (@(posedge clk)
    disable iff (!rst_n) cmd.emit |-> (!out_valid_r || out_tready))
    else $error("result loaded over a pending result");

  a_hit_on_grid: assert property (@(posedge clk)
    disable iff (!rst_n) cmd.hist_wr |-> in_r)
    else $error("histogram raised for a point outside the grid");

endmodule

`default_nettype wire

// File: hdl/eoh_ctrl.sv
// ----------------------------------------------------------------------------
// eoh_ctrl
// Sequencer for clearing, orbit iteration, replay and cell reads.
// ----------------------------------------------------------------------------
`default_nettype none

module eoh_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_ready,
  input  wire eoh_pkg::sts_t sts,
  output eoh_pkg::cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_MUL, ST_ADD, ST_CHK, ST_ORD, ST_MAP, ST_DIV,
    ST_DWAIT, ST_HWR, ST_LRD, ST_LWAIT, ST_LDIV, ST_DONE
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_end) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          cmd.start = 1'b1;
          if (sts.op_read)        state_nxt = ST_LRD;
          else if (sts.zero_iter) state_nxt = ST_DONE;
          else                    state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        cmd.add   = 1'b1;
        state_nxt = ST_CHK;
      end
      ST_CHK: begin
        cmd.check = 1'b1;
        priority if (sts.esc_now) state_nxt = sts.rec_ok ? ST_ORD : ST_DONE;
        else if (sts.last_iter)   state_nxt = ST_DONE;
        else                      state_nxt = ST_MUL;
      end
      ST_ORD: begin
        if (sts.rep_end) begin
          state_nxt = ST_DONE;
        end else begin
          cmd.orb_rd = 1'b1;
          state_nxt  = ST_MAP;
        end
      end
      ST_MAP: begin
        cmd.map   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (sts.on_grid) begin
          cmd.div_start = 1'b1;
          state_nxt     = ST_DWAIT;
        end else begin
          state_nxt = ST_ORD;
        end
      end
      ST_DWAIT: begin
        if (!sts.div_busy) begin
          cmd.hist_rd_map = 1'b1;
          state_nxt       = ST_HWR;
        end
      end
      ST_HWR: begin
        cmd.hist_wr = 1'b1;
        state_nxt   = ST_ORD;
      end
      ST_LRD: begin
        cmd.hist_rd_idx = 1'b1;
        state_nxt       = ST_LWAIT;
      end
      ST_LWAIT: begin
        cmd.lvl_start = 1'b1;
        state_nxt     = ST_LDIV;
      end
      ST_LDIV: begin
        if (!sts.lvl_busy) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = state_r == ST_IDLE;

endmodule

`default_nettype wire

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the escape orbit histogram engine.
// ----------------------------------------------------------------------------
// Traces points and reads cells on the stream input. Every accepted item runs
// through a local histogram predictor that iterates z*z+c in Q4.28, replays the
// orbit into a mirror of the hit counters, and queues the expected result. The
// result checker compares each accepted result, field by field, with the
// oldest expectation. Several register settings are used, from reset values to
// extremes, with random gaps on the input side and random stalls on the output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit         OP_TRACE   = 1'b0;
  localparam bit         OP_READ    = 1'b1;
  localparam int         FRAC       = eoh_pkg::FRAC_BITS_DEF;
  localparam int         SIDE       = eoh_pkg::GRID_SIDE_DEF;
  localparam int         DEPTH      = eoh_pkg::ORBIT_DEPTH_DEF;
  localparam longint     ONE        = longint'(1) << FRAC;
  localparam longint     CYCLE_CAP  = 8000000;
  localparam int         DRAIN_WAIT = 8;

  // Field order mirrors out_tdata from the highest bit down
  typedef struct packed {
    logic [7:0]  cell_level;
    logic [31:0] cell_count;
    logic [10:0] plotted;
    logic [10:0] escape_step;
    logic        escaped;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [eoh_pkg::IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [eoh_pkg::OUT_DATA_W-1:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [eoh_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [eoh_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  escape_orbit_histogram i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #5 clk = ~clk;

  // Mirror of the engine state and registers
  int unsigned hit_counts[int unsigned];
  int unsigned hit_cells[$];
  int unsigned peak_count;
  longint      orbit_re[DEPTH];
  longint      orbit_im[DEPTH];
  int unsigned max_iter;
  int unsigned min_iter;
  longint      esc_limit;
  int unsigned plot_range;

  result_t expected_results[$];
  int      mismatches = 0;
  longint  cycles = 0;
  bit      gaps_on = 1'b1;
  int      stall_left = 0;

  // Hard stop on a hang
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint mag(longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Add one orbit point to the histogram when it falls inside the square
  function automatic bit plot_point(longint re, longint im);
    longint span, ux, uy, x, y;
    int unsigned cell_no;
    span = longint'((plot_range != 0) ? plot_range : 1) << FRAC;
    ux = re + span;
    uy = im + span;
    if (ux < 0 || uy < 0 || ux > 2 * span || uy > 2 * span) return 1'b0;
    x = ux * (SIDE - 1) / (2 * span);
    y = uy * (SIDE - 1) / (2 * span);
    cell_no = int'(x + y * SIDE);
    if (!hit_counts.exists(cell_no)) begin
      hit_counts[cell_no] = 0;
      hit_cells.push_back(cell_no);
    end
    if (hit_counts[cell_no] != eoh_pkg::COUNT_MAX) hit_counts[cell_no]++;
    if (hit_counts[cell_no] > peak_count) peak_count = hit_counts[cell_no];
    return 1'b1;
  endfunction

  function automatic result_t trace_orbit(longint cr, longint ci);
    result_t     r;
    longint      zr, zi, nr, ni;
    int unsigned k, n, cnt, plotted;
    r = '0;
    zr = cr;
    zi = ci;
    plotted = 0;
    r.escape_step = max_iter[10:0];
    for (k = 0; k < max_iter; k++) begin
      nr = (zr * zr - zi * zi) >>> FRAC;
      ni = (zr * zi) >>> (FRAC - 1);
      zr = sat32(nr + cr);
      zi = sat32(ni + ci);
      if (k >= min_iter && k - min_iter < DEPTH) begin
        orbit_re[k - min_iter] = zr;
        orbit_im[k - min_iter] = zi;
      end
      if (mag(zr - cr) + mag(zi - ci) > esc_limit) begin
        r.escaped = 1'b1;
        r.escape_step = k[10:0];
        // early escape leaves the histogram alone
        if (k >= min_iter) begin
          cnt = k - min_iter + 1;
          if (cnt > DEPTH) cnt = DEPTH;
          for (n = 0; n < cnt; n++)
            if (plot_point(orbit_re[n], orbit_im[n])) plotted++;
        end
        break;
      end
    end
    r.plotted = plotted[10:0];
    return r;
  endfunction

  function automatic result_t read_cell(int unsigned idx);
    result_t     r;
    int unsigned cnt;
    longint      lvl;
    r = '0;
    cnt = hit_counts.exists(idx) ? hit_counts[idx] : 0;
    lvl = (peak_count != 0) ?
          longint'(cnt) * eoh_pkg::LEVEL_SCALE / longint'(peak_count) : 0;
    r.cell_count = cnt;
    r.cell_level = lvl[7:0];
    return r;
  endfunction

  // Hold the item until accepted, then queue its prediction
  task automatic send_item(bit op, longint cre, longint cim, int unsigned idx);
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = op;
    in_tdata  = {idx[15:0], cim[31:0], cre[31:0]};
    do @(posedge clk); while (!in_tready);
    if (op == OP_TRACE) expected_results.push_back(trace_orbit(cre, cim));
    else expected_results.push_back(read_cell(idx));
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (expected_results.size() != 0) @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(logic [eoh_pkg::CFG_ADDR_W-1:0] addr, longint value);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_addr  = addr;
    cfg_wdata = value[eoh_pkg::CFG_DATA_W-1:0];
    case (addr)
      eoh_pkg::REG_MAX_ITER:  max_iter   = int'(value & 'h7FF);
      eoh_pkg::REG_MIN_ITER:  min_iter   = int'(value & 'h3FF);
      eoh_pkg::REG_ESC_LIMIT: esc_limit  = value & 'h7FFF_FFFF;
      eoh_pkg::REG_RANGE:     plot_range = int'(value & 'h7);
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Drain first; registers only change while the engine is idle
  task automatic set_config(longint mx, longint mn, longint lim, longint rg);
    drain();
    write_reg(eoh_pkg::REG_MAX_ITER, mx);
    write_reg(eoh_pkg::REG_MIN_ITER, mn);
    write_reg(eoh_pkg::REG_ESC_LIMIT, lim);
    write_reg(eoh_pkg::REG_RANGE, rg);
  endtask

  function automatic longint near_point();
    return longint'($urandom_range(0, 32'd1342177280)) - 64'sd671088640;
  endfunction

  function automatic longint any_point();
    return longint'($signed($urandom));
  endfunction

  function automatic int unsigned pick_cell();
    if (hit_cells.size() != 0 && $urandom_range(0, 3) != 0)
      return hit_cells[$urandom_range(0, hit_cells.size() - 1)];
    return $urandom_range(0, 65535);
  endfunction

  // Output side: random stall bursts while gaps are on
  always @(negedge clk) begin
    if (!gaps_on) begin
      out_tready <= 1'b1;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_tready <= 1'b0;
      stall_left <= int'($urandom_range(0, 7));
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[eoh_pkg::OUT_DATA_W-2:0];
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", out_tdata);
      end else begin
        want = expected_results.pop_front();
        if (got.escaped !== want.escaped || got.escape_step !== want.escape_step ||
            got.plotted !== want.plotted || got.cell_count !== want.cell_count ||
            got.cell_level !== want.cell_level ||
            out_tdata[eoh_pkg::OUT_DATA_W-1] !== 1'b0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: esc %0d/%0d step %0d/%0d plot %0d/%0d cnt %0d/%0d lvl %0d/%0d",
                     want.escaped, got.escaped, want.escape_step, got.escape_step,
                     want.plotted, got.plotted, want.cell_count, got.cell_count,
                     want.cell_level, got.cell_level);
        end
      end
    end
  end

  // Reset registers, fixed corner points, reads before and after hits
  task automatic test_reset_defaults();
    send_item(OP_READ, 0, 0, 0);
    send_item(OP_TRACE, 0, 0, 0);
    send_item(OP_TRACE, ONE, 0, 16'hFFFF);
    send_item(OP_TRACE, -64'sd2147483648, 64'sd2147483647, 0);
    send_item(OP_TRACE, 64'sd2147483647, -64'sd2147483648, 0);
    send_item(OP_TRACE, -ONE / 2, ONE / 2, 0);
    send_item(OP_TRACE, ONE * 3 / 10, ONE / 2, 0);
    send_item(OP_TRACE, -2 * ONE, 0, 0);
    send_item(OP_READ, 0, 0, 65535);
    send_item(OP_READ, -1, -1, pick_cell());
  endtask

  // Early escape, zero iterations, zero limit, zero range, widest settings
  task automatic test_register_extremes();
    set_config(1024, 5, 64'sd1073741824, 2);
    send_item(OP_TRACE, 3 * ONE / 2, 3 * ONE / 2, 0);
    set_config(0, 0, 64'sd1073741824, 2);
    send_item(OP_TRACE, ONE, ONE, 0);
    set_config(40, 0, 0, 0);
    send_item(OP_TRACE, ONE / 4, -ONE / 4, 0);
    send_item(OP_TRACE, 0, 0, 0);
    set_config(1, 1023, 64'sd2147483647, 7);
    send_item(OP_TRACE, ONE * 3, -ONE * 3, 0);
    set_config(64, 0, 64'sd2147483647, 7);
    send_item(OP_TRACE, ONE * 3 / 10, ONE * 6 / 10, 0);
    send_item(OP_READ, 0, 0, pick_cell());
  endtask

  // Slow escape near the cusp pushes the orbit past the store depth
  task automatic test_long_orbit();
    set_config(2047, 0, 64'sd1073741824, 1);
    send_item(OP_TRACE, ONE / 4 + 1500, 0, 0);
    send_item(OP_TRACE, ONE / 4 + 6000, 0, 0);
    send_item(OP_READ, 0, 0, pick_cell());
  endtask

  task automatic test_random_traffic(int unsigned items);
    int unsigned i, sel;
    for (i = 0; i < items; i++) begin
      if (i % 30 == 0)
        set_config($urandom_range(1, 96), $urandom_range(0, 6),
                   longint'($urandom_range(32'h1000_0000, 32'h7FFF_FFFF)),
                   $urandom_range(0, 7));
      if (i == items - 60) gaps_on = 1'b0;
      sel = $urandom_range(0, 9);
      if (sel < 6) send_item(OP_TRACE, near_point(), near_point(), $urandom_range(0, 65535));
      else if (sel < 7) send_item(OP_TRACE, any_point(), any_point(), $urandom_range(0, 65535));
      else send_item(OP_READ, any_point(), any_point(), pick_cell());
    end
  endtask

  initial begin
    peak_count = 0;
    max_iter   = eoh_pkg::MAX_ITER_RST;
    min_iter   = eoh_pkg::MIN_ITER_RST;
    esc_limit  = eoh_pkg::ESC_LIMIT_RST;
    plot_range = eoh_pkg::RANGE_RST;
    repeat (11) @(negedge clk);
    rst_n = 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_long_orbit();
    test_random_traffic(265);
    drain();
    repeat (200) @(negedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: escape_orbit_histogram.f
hdl/eoh_pkg.sv
hdl/eoh_div.sv
hdl/eoh_dp.sv
hdl/eoh_ctrl.sv
hdl/escape_orbit_histogram.sv
sim/tb.sv
